// File: design/hc22_pkg.sv
// ----------------------------------------------------------------------------
// hc22_pkg
// Shared types, register codes and arithmetic helpers for the 2x2 Hill cipher
// on bytes.
// ----------------------------------------------------------------------------
package hc22_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE  = 3'd4;

    // Input word: one message byte.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       message_end;
    } t_in_word;

    // Output word: one transformed byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       pair_last;
        logic       stream_end;
    } t_out_word;

    // Sequencer that derives the decrypt matrix after a key write.
    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_DET,
        KEY_INV,
        KEY_COEF
    } t_key_state;

    typedef logic [7:0] t_byte_table [256];

    // Low byte of an 8x8 product, i.e. the product modulo 256.
    function automatic logic [7:0] f_mul8(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        p = a * b;
        return p[7:0];
    endfunction

    // Multiplicative inverse modulo 256 for every byte; 1 where none exists.
    // Built at elaboration, searched downward so the smallest solution wins.
    function automatic t_byte_table f_build_inv();
        t_byte_table t;
        logic [15:0] p;
        for (int d = 0; d < 256; d++) begin
            t[d] = 8'd1;
            for (int i = 255; i >= 1; i--) begin
                p = 16'(d * i);
                if (p[7:0] == 8'd1) begin
                    t[d] = 8'(i);
                end
            end
        end
        return t;
    endfunction

    localparam t_byte_table INV_TABLE = f_build_inv();

endpackage

// File: design/hill_cipher_2x2_bytes.sv
// ----------------------------------------------------------------------------
// hill_cipher_2x2_bytes
// Pairs a byte stream and multiplies each pair by a 2x2 matrix modulo 256,
// using the key matrix to encrypt or its inverse to decrypt.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+------------------------------
//  in      | input     | valid / stall      | in_byte, message_end
//  out     | output    | valid / stall      | out_byte, pair_last, stream_end
//  cfg     | input     | valid / ready      | register index, 8-bit data
//
// One input word is taken per cycle unless stalled; a completed pair is computed
// in the same cycle and both result words enter a three-entry output queue,
// which drains one word per cycle unless the output stalls. A key write makes
// the block busy for the determinant, inverse lookup and coefficient steps;
// cfg ready and the input stall show it. Reset restores the identity key and
// an empty queue. Input stall rises when the queue could not take two more words.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_bytes (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  hc22_pkg::t_in_word              i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output hc22_pkg::t_out_word             o_out_data,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hc22_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hc22_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hc22_pkg::*;

    localparam int FIFO_DEPTH = 3;

    logic [7:0] r_key_a, r_key_b, r_key_c, r_key_d;
    logic       r_mode;
    logic [7:0] r_inv_a, r_inv_b, r_inv_c, r_inv_d;
    logic [7:0] r_det, r_inv;
    t_key_state r_key_state, n_key_state;

    logic       r_held_valid;
    logic [7:0] r_held_byte;

    t_out_word  r_fifo [FIFO_DEPTH];
    logic [1:0] r_wr_ptr, r_rd_ptr, r_cnt;

    logic       cfg_write, key_write;
    logic       in_accept, push, pop;
    logic [7:0] x, y, m0, m1, m2, m3, res0, res1;

    function automatic logic [1:0] f_ptr_next(input logic [1:0] p);
        return (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    // ---------------- configuration ----------------
    assign o_cfg_ready = (r_key_state == KEY_IDLE);
    assign cfg_write = i_cfg_valid && o_cfg_ready;
    assign key_write = cfg_write && (i_cfg_index == CFG_KEY_A || i_cfg_index == CFG_KEY_B
                                  || i_cfg_index == CFG_KEY_C || i_cfg_index == CFG_KEY_D);

    always_comb begin
        n_key_state = r_key_state;
        case (r_key_state)
            KEY_IDLE: begin
                if (key_write) begin
                    n_key_state = KEY_DET;
                end
            end
            KEY_DET:  n_key_state = KEY_INV;
            KEY_INV:  n_key_state = KEY_COEF;
            KEY_COEF: n_key_state = KEY_IDLE;
            default:  n_key_state = KEY_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_state <= KEY_IDLE;
            r_key_a     <= 8'd1;
            r_key_b     <= 8'd0;
            r_key_c     <= 8'd0;
            r_key_d     <= 8'd1;
            r_mode      <= 1'b0;
            r_inv_a     <= 8'd1;
            r_inv_b     <= 8'd0;
            r_inv_c     <= 8'd0;
            r_inv_d     <= 8'd1;
        end else begin
            r_key_state <= n_key_state;
            if (cfg_write) begin
                case (i_cfg_index)
                    CFG_KEY_A: r_key_a <= i_cfg_data;
                    CFG_KEY_B: r_key_b <= i_cfg_data;
                    CFG_KEY_C: r_key_c <= i_cfg_data;
                    CFG_KEY_D: r_key_d <= i_cfg_data;
                    CFG_MODE:  r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_key_state == KEY_COEF) begin
                r_inv_a <= f_mul8(r_inv, r_key_d);
                r_inv_b <= 8'd0 - f_mul8(r_inv, r_key_b);
                r_inv_c <= 8'd0 - f_mul8(r_inv, r_key_c);
                r_inv_d <= f_mul8(r_inv, r_key_a);
            end
        end
    end

    // Determinant and its inverse are plain data registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_key_state == KEY_DET) begin
            r_det <= f_mul8(r_key_a, r_key_d) - f_mul8(r_key_b, r_key_c);
        end
        if (r_key_state == KEY_INV) begin
            r_inv <= INV_TABLE[r_det];
        end
    end

    // ---------------- data path ----------------
    assign pop        = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_key_state != KEY_IDLE) || (r_cnt == 2'd3)
                     || (r_cnt == 2'd2 && !pop);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign push       = in_accept && (r_held_valid || i_in_data.message_end);

    always_comb begin
        x = r_held_valid ? r_held_byte : i_in_data.in_byte;
        y = r_held_valid ? i_in_data.in_byte : 8'd0;
        m0 = r_mode ? r_inv_a : r_key_a;
        m1 = r_mode ? r_inv_b : r_key_b;
        m2 = r_mode ? r_inv_c : r_key_c;
        m3 = r_mode ? r_inv_d : r_key_d;
        res0 = f_mul8(m0, x) + f_mul8(m1, y);
        res1 = f_mul8(m2, x) + f_mul8(m3, y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_byte  <= 8'd0;
            r_wr_ptr     <= 2'd0;
            r_rd_ptr     <= 2'd0;
            r_cnt        <= 2'd0;
        end else begin
            if (in_accept) begin
                // A lone first byte is held unless it also ends the message.
                r_held_valid <= !r_held_valid && !i_in_data.message_end;
                r_held_byte  <= (!r_held_valid && !i_in_data.message_end)
                              ? i_in_data.in_byte : 8'd0;
            end
            if (push) begin
                r_wr_ptr <= f_ptr_next(f_ptr_next(r_wr_ptr));
            end
            if (pop) begin
                r_rd_ptr <= f_ptr_next(r_rd_ptr);
            end
            r_cnt <= r_cnt - {1'b0, pop} + (push ? 2'd2 : 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr]             <= '{out_byte: res0, pair_last: 1'b0,
                                              stream_end: 1'b0};
            r_fifo[f_ptr_next(r_wr_ptr)] <= '{out_byte: res1, pair_last: 1'b1,
                                              stream_end: i_in_data.message_end};
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_fifo[r_rd_ptr];

endmodule

// File: design/hc22_checker.sv
// ----------------------------------------------------------------------------
// hc22_checker
// Port-level checks for the 2x2 Hill cipher, bound to the top level.
// ----------------------------------------------------------------------------
module hc22_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input hc22_pkg::t_in_word              i_in_data,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input hc22_pkg::t_out_word             o_out_data,
    input logic                            i_out_stall,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [hc22_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input logic [hc22_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hc22_pkg::*;

    // A key write keeps the block busy through the determinant, inverse lookup and coefficient steps.
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_KEY_A || i_cfg_index == CFG_KEY_B
            || i_cfg_index == CFG_KEY_C || i_cfg_index == CFG_KEY_D))
        |=> !o_cfg_ready ##1 !o_cfg_ready ##1 !o_cfg_ready ##1 o_cfg_ready)
        else $error("key write busy window wrong");

    // No data word is taken while the decrypt matrix is being derived.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> o_in_stall)
        else $error("input taken while key sequencer busy");

    // The end of a message always falls on the second word of a pair.
    a_end_on_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.stream_end) |-> o_out_data.pair_last)
        else $error("stream_end on a first word");

    // A first word is always followed by its second word.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.pair_last)
        |=> o_out_valid && o_out_data.pair_last)
        else $error("second word of pair missing");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

endmodule

bind hill_cipher_2x2_bytes hc22_checker u_hc22_checker (.*);
